// File: hw/rtl/hid_key_set_report_builder_top_assert.svh
// Assertion macros for the key set report builder.
`ifndef HID_KEY_SET_REPORT_BUILDER_TOP_ASSERT_SVH
`define HID_KEY_SET_REPORT_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HKRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkrb assertion failed");

// Next-cycle implication, checked out of reset.
`define HKRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkrb assertion failed");

`endif

// File: hw/rtl/hkrb_pkg.sv
package hkrb_pkg;

  localparam int HELD_SLOTS  = 6;
  localparam int TABLE_DEPTH = 256;
  localparam int REPORT_KEYS = 6;

  localparam int KEY_W   = 8;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 8;
  localparam int TSIZE_W = 9;

  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_IW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
  localparam int SLOT_CW = $clog2(HELD_SLOTS + 1);
  localparam int RPT_IW  = $clog2(REPORT_KEYS);
  localparam int RPT_CW  = $clog2(REPORT_KEYS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PRESS       = 3'd0,
    OP_RELEASE     = 3'd1,
    OP_RELEASE_ALL = 3'd2,
    OP_REPORT      = 3'd3,
    OP_LOAD        = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SLOT,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] limit;
  } find_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [KEY_W-1:0] code;
  } find_rsp_t;

endpackage

// File: hw/rtl/hkrb_if.sv
interface hkrb_in_if;
  import hkrb_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key_value;
  logic [IDX_W-1:0] table_index;
  modport source (output valid, operation, key_value, table_index, input ready);
  modport sink   (input valid, operation, key_value, table_index, output ready);
endinterface

interface hkrb_out_if;
  import hkrb_pkg::*;
  logic             valid;
  logic             ready;
  logic             changed;
  logic [KEY_W-1:0] report_key1;
  logic [KEY_W-1:0] report_key2;
  logic [KEY_W-1:0] report_key3;
  logic [KEY_W-1:0] report_key4;
  logic [KEY_W-1:0] report_key5;
  logic [KEY_W-1:0] report_key6;
  modport source (output valid, changed, report_key1, report_key2, report_key3,
                  report_key4, report_key5, report_key6, input ready);
  modport sink   (input valid, changed, report_key1, report_key2, report_key3,
                  report_key4, report_key5, report_key6, output ready);
endinterface

interface hkrb_cfg_if;
  import hkrb_pkg::*;
  logic               valid;
  logic               ready;
  logic [TSIZE_W-1:0] table_size;
  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface

// File: hw/rtl/hid_key_set_report_builder_top.sv
// Channel  | Dir | Word
// in_ch    | in  | operation, key_value, table_index
// out_ch   | out | changed, report_key1 .. report_key6
// cfg_ch   | in  | table_size
//
// Press, release, release all, load and unused codes pass through ST_IDLE and ST_EXEC.
// Report: ST_SLOT starts a table scan for each held slot, over at most
// min(table_size, 256) entries, one RAM read per cycle.
// One word in work at a time; the next is taken while a result waits in the
// output register. Reset clears the held slots and the changed flag; the
// table RAM is not cleared. cfg_ch is always ready.
module hid_key_set_report_builder_top (
  input logic       clk_i,
  input logic       rst_ni,
  hkrb_in_if.sink   in_ch,
  hkrb_out_if.source out_ch,
  hkrb_cfg_if.sink  cfg_ch
);
  import hkrb_pkg::*;

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   idx_q;
  logic [KEY_W-1:0]   slots_q [HELD_SLOTS];
  logic [KEY_W-1:0]   slots_d [HELD_SLOTS];
  logic               changed_q, changed_d;
  logic [TSIZE_W-1:0] tsize_q;
  logic [SLOT_CW-1:0] slot_idx_q, slot_idx_d;
  logic [RPT_CW-1:0]  rpt_cnt_q, rpt_cnt_d;
  logic [KEY_W-1:0]   rpt_q [REPORT_KEYS];
  logic [KEY_W-1:0]   rpt_d [REPORT_KEYS];
  logic               out_valid_q, out_valid_d;
  logic               out_changed_q, out_changed_d;
  logic [KEY_W-1:0]   out_key_q [REPORT_KEYS];
  logic [KEY_W-1:0]   out_key_d [REPORT_KEYS];

  logic               in_acc, out_free;
  logic [CNT_W-1:0]   limit;
  logic               held, has_empty;
  logic [SLOT_IW-1:0] first_empty;
  logic [KEY_W-1:0]   cur_slot;
  logic               ram_we;
  find_req_t          find_req;
  find_rsp_t          find_rsp;
  logic               rd_en;
  logic [TBL_AW-1:0]  rd_addr;
  logic [KEY_W-1:0]   rd_data;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;
  assign limit    = (tsize_q > TSIZE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(tsize_q);
  assign cur_slot = slots_q[slot_idx_q[SLOT_IW-1:0]];
  assign ram_we   = (state_q == ST_EXEC) && (op_q == OP_LOAD) && out_free &&
                    (TSIZE_W'(idx_q) < TSIZE_W'(TABLE_DEPTH));

  always_comb begin
    held        = 1'b0;
    has_empty   = 1'b0;
    first_empty = '0;
    for (int n = HELD_SLOTS - 1; n >= 0; n--) begin
      if (slots_q[n] == key_q) begin
        held = 1'b1;
      end
      if (slots_q[n] == '0) begin
        has_empty   = 1'b1;
        first_empty = SLOT_IW'(n);
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    slots_d       = slots_q;
    changed_d     = changed_q;
    slot_idx_d    = slot_idx_q;
    rpt_cnt_d     = rpt_cnt_q;
    rpt_d         = rpt_q;
    out_valid_d   = out_valid_q && !out_ch.ready;
    out_changed_d = out_changed_q;
    out_key_d     = out_key_q;
    find_req      = '0;
    in_ch.ready   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_q == OP_REPORT) begin
          slot_idx_d = '0;
          rpt_cnt_d  = '0;
          rpt_d      = '{default: '0};
          state_d    = ST_SLOT;
        end else if (out_free) begin
          unique case (op_q)
            OP_PRESS: begin
              if (!held) begin
                if (has_empty) begin
                  slots_d[first_empty] = key_q;
                end
                changed_d = 1'b1;
              end
            end
            OP_RELEASE: begin
              for (int n = 0; n < HELD_SLOTS; n++) begin
                if (slots_q[n] == key_q) begin
                  slots_d[n] = '0;
                end
              end
              changed_d = 1'b1;
            end
            OP_RELEASE_ALL: begin
              slots_d   = '{default: '0};
              changed_d = 1'b1;
            end
            default: begin
            end
          endcase
          out_valid_d   = 1'b1;
          out_changed_d = changed_d;
          out_key_d     = '{default: '0};
          state_d       = ST_IDLE;
        end
      end
      ST_SLOT: begin
        if (slot_idx_q == SLOT_CW'(HELD_SLOTS)) begin
          state_d = ST_DONE;
        end else if (cur_slot == '0) begin
          slot_idx_d = slot_idx_q + SLOT_CW'(1);
        end else begin
          find_req.start = 1'b1;
          find_req.key   = cur_slot;
          find_req.limit = limit;
          state_d        = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (find_rsp.done) begin
          if (find_rsp.found && (rpt_cnt_q < RPT_CW'(REPORT_KEYS))) begin
            rpt_d[rpt_cnt_q[RPT_IW-1:0]] = find_rsp.code;
            rpt_cnt_d = rpt_cnt_q + RPT_CW'(1);
          end
          slot_idx_d = slot_idx_q + SLOT_CW'(1);
          state_d    = ST_SLOT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          changed_d     = 1'b0;
          out_valid_d   = 1'b1;
          out_changed_d = 1'b0;
          out_key_d     = rpt_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slots_q     <= '{default: '0};
      changed_q   <= 1'b0;
      tsize_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slots_q     <= slots_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
      if (cfg_ch.valid) begin
        tsize_q <= cfg_ch.table_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_ch.operation;
      key_q <= in_ch.key_value;
      idx_q <= in_ch.table_index;
    end
    slot_idx_q    <= slot_idx_d;
    rpt_cnt_q     <= rpt_cnt_d;
    rpt_q         <= rpt_d;
    out_changed_q <= out_changed_d;
    out_key_q     <= out_key_d;
  end

  hkrb_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[TBL_AW-1:0]),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  hkrb_keyfind u_find (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (find_req),
    .rsp_o     (find_rsp),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_q;
  assign out_ch.changed     = out_changed_q;
  assign out_ch.report_key1 = out_key_q[0];
  assign out_ch.report_key2 = out_key_q[1];
  assign out_ch.report_key3 = out_key_q[2];
  assign out_ch.report_key4 = out_key_q[3];
  assign out_ch.report_key5 = out_key_q[4];
  assign out_ch.report_key6 = out_key_q[5];

endmodule

// File: hw/rtl/hkrb_ram.sv
module hkrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hkrb_keyfind.sv
module hkrb_keyfind (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hkrb_pkg::find_req_t        req_i,
  output hkrb_pkg::find_rsp_t        rsp_o,
  output logic                       rd_en_o,
  output logic [hkrb_pkg::TBL_AW-1:0] rd_addr_o,
  input  logic [hkrb_pkg::KEY_W-1:0] rd_data_i
);
  import hkrb_pkg::*;

  logic              busy_q, busy_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  addr_q, addr_d;
  logic [TBL_AW-1:0] pend_addr_q, pend_addr_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic              match, issue, done;

  // one read in flight; data of the previous address is compared each cycle
  assign match = pend_q && (rd_data_i == key_q);
  assign done  = busy_q && (match || (addr_q >= limit_q));
  assign issue = busy_q && (addr_q < limit_q) && !match;

  always_comb begin
    busy_d      = busy_q;
    pend_d      = pend_q;
    addr_d      = addr_q;
    pend_addr_d = pend_addr_q;
    key_d       = key_q;
    limit_d     = limit_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      pend_d  = 1'b0;
      addr_d  = '0;
      key_d   = req_i.key;
      limit_d = req_i.limit;
    end else if (done) begin
      busy_d = 1'b0;
      pend_d = 1'b0;
    end else begin
      pend_d = issue;
      if (issue) begin
        addr_d      = addr_q + CNT_W'(1);
        pend_addr_d = addr_q[TBL_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    pend_addr_q <= pend_addr_d;
    key_q       <= key_d;
    limit_q     <= limit_d;
  end

  assign rd_en_o     = issue;
  assign rd_addr_o   = addr_q[TBL_AW-1:0];
  assign rsp_o.done  = done;
  assign rsp_o.found = match;
  assign rsp_o.code  = KEY_W'(pend_addr_q);

endmodule

// File: hw/rtl/hkrb_checker.sv
`include "hid_key_set_report_builder_top_assert.svh"

module hkrb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_changed_i,
  input logic [hkrb_pkg::KEY_W-1:0] key1_i,
  input logic [hkrb_pkg::KEY_W-1:0] key2_i,
  input logic [hkrb_pkg::KEY_W-1:0] key3_i,
  input logic [hkrb_pkg::KEY_W-1:0] key4_i,
  input logic [hkrb_pkg::KEY_W-1:0] key5_i,
  input logic [hkrb_pkg::KEY_W-1:0] key6_i
);
  import hkrb_pkg::*;

  logic any_key;
  assign any_key = (key1_i != '0) || (key2_i != '0) || (key3_i != '0) ||
                   (key4_i != '0) || (key5_i != '0) || (key6_i != '0);

  // one word in work at a time
  `HKRB_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // only a report carries keycodes, and a report clears changed
  `HKRB_ASSERT_NOW(a_report_clears, clk_i, rst_ni, out_valid_i && any_key, !out_changed_i)
  `HKRB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `HKRB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_changed_i) && $stable(key1_i) && $stable(key6_i))

endmodule

bind hid_key_set_report_builder_top hkrb_checker u_hkrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_changed_i (out_ch.changed),
  .key1_i        (out_ch.report_key1),
  .key2_i        (out_ch.report_key2),
  .key3_i        (out_ch.report_key3),
  .key4_i        (out_ch.report_key4),
  .key5_i        (out_ch.report_key5),
  .key6_i        (out_ch.report_key6)
);

// File: tb/sv/hkrb_report_checker.sv
`timescale 1ns / 100ps

module hkrb_report_checker
  import hkrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hkrb_in_if   in_ch,
  hkrb_out_if  out_ch,
  hkrb_cfg_if  cfg_ch,
  output int   errors_o,
  output int   pending_o,
  output int   results_o,
  output int   reports_o
);

  typedef struct packed {
    logic                              changed;
    logic [REPORT_KEYS-1:0][KEY_W-1:0] keys;
  } hid_report_t;

  logic [KEY_W-1:0]   held_keys [HELD_SLOTS];
  logic [KEY_W-1:0]   key_table [TABLE_DEPTH];
  logic               changed_flag;
  logic [TSIZE_W-1:0] table_size_q;
  hid_report_t        expected_reports [$];

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors_o++;
  endtask

  function automatic hid_report_t apply_key_word(input logic [OP_W-1:0]  op,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [IDX_W-1:0] idx);
    hid_report_t rpt;
    logic        held;
    logic        placed;
    logic        found;
    int          limit;
    int          count;
    int          code;
    int          s;
    int          i;
    rpt  = '0;
    code = 0;
    case (op)
      OP_PRESS: begin
        // a zero code matches an empty slot, so it counts as held
        held = 1'b0;
        for (s = 0; s < HELD_SLOTS; s++) begin
          if (held_keys[s] == key) held = 1'b1;
        end
        if (!held) begin
          placed = 1'b0;
          for (s = 0; s < HELD_SLOTS; s++) begin
            if (!placed && held_keys[s] == '0) begin
              held_keys[s] = key;
              placed       = 1'b1;
            end
          end
          changed_flag = 1'b1;
        end
      end
      OP_RELEASE: begin
        for (s = 0; s < HELD_SLOTS; s++) begin
          if (held_keys[s] == key) held_keys[s] = '0;
        end
        changed_flag = 1'b1;
      end
      OP_RELEASE_ALL: begin
        for (s = 0; s < HELD_SLOTS; s++) held_keys[s] = '0;
        changed_flag = 1'b1;
      end
      OP_REPORT: begin
        limit = (table_size_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size_q);
        count = 0;
        for (s = 0; s < HELD_SLOTS; s++) begin
          if (held_keys[s] != '0) begin
            found = 1'b0;
            for (i = 0; i < limit && !found; i++) begin
              if (key_table[i] == held_keys[s]) begin
                found = 1'b1;
                code  = i;
              end
            end
            if (found) begin
              if (count < REPORT_KEYS) rpt.keys[count] = KEY_W'(code);
              count++;
            end
          end
        end
        changed_flag = 1'b0;
      end
      OP_LOAD: begin
        key_table[idx] = key;
      end
      default: begin
      end
    endcase
    rpt.changed = changed_flag;
    return rpt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hid_report_t got;
    hid_report_t want;
    if (!rst_ni) begin
      for (int s = 0; s < HELD_SLOTS; s++) held_keys[s] = '0;
      changed_flag = 1'b0;
      table_size_q = '0;
      expected_reports.delete();
      pending_o = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) table_size_q = cfg_ch.table_size;
      if (out_ch.valid && out_ch.ready) begin
        got.changed = out_ch.changed;
        got.keys    = {out_ch.report_key6, out_ch.report_key5, out_ch.report_key4,
                       out_ch.report_key3, out_ch.report_key2, out_ch.report_key1};
        results_o++;
        if (expected_reports.size() == 0) begin
          note_mismatch($sformatf("result word %0d with nothing expected", results_o));
        end else begin
          want = expected_reports.pop_front();
          if (got.changed !== want.changed) begin
            note_mismatch($sformatf("result word %0d: changed got %0b want %0b",
                                    results_o, got.changed, want.changed));
          end
          for (int k = 0; k < REPORT_KEYS; k++) begin
            if (got.keys[k] !== want.keys[k]) begin
              note_mismatch($sformatf("result word %0d: key%0d got %02h want %02h",
                                      results_o, k + 1, got.keys[k], want.keys[k]));
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_REPORT) reports_o++;
        expected_reports.push_back(apply_key_word(in_ch.operation, in_ch.key_value,
                                                  in_ch.table_index));
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

// File: tb/sv/hid_key_set_report_builder_top_tb.sv
`timescale 1ns / 100ps

module hid_key_set_report_builder_top_tb;
  import hkrb_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO   = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI   = 3'd7;
  localparam int              RAND_SEGMENTS = 6;
  localparam int              SEGMENT_WORDS = 16;
  localparam int              CYCLE_LIMIT   = 5_000_000;

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   cycle_cnt     = 0;
  int   words_sent    = 0;
  int   cur_tsize     = 0;
  int   errors;
  int   pending;
  int   results;
  int   reports;

  logic [KEY_W-1:0] tbl_shadow [TABLE_DEPTH];
  logic [KEY_W-1:0] pressed_keys [$];

  hkrb_in_if  in_ch ();
  hkrb_out_if out_ch ();
  hkrb_cfg_if cfg_ch ();

  hid_key_set_report_builder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  hkrb_report_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results),
    .reports_o (reports)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("hid_key_set_report_builder_top_tb: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // entered and left at a falling edge; valid is left high for the next word
  task automatic put_word(input logic [OP_W-1:0]  op,
                          input logic [KEY_W-1:0] key,
                          input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.key_value   <= key;
    in_ch.table_index <= idx;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    if (op == OP_LOAD) tbl_shadow[idx] = key;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_table_size(input logic [TSIZE_W-1:0] size);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.table_size <= size;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    cur_tsize = size;
  endtask

  task automatic random_word();
    int               roll;
    int               lim;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(99);
    lim  = (cur_tsize > TABLE_DEPTH) ? TABLE_DEPTH : cur_tsize;
    key  = KEY_W'($urandom);
    if (roll < 35) begin
      // mostly characters the table knows, so reports carry keycodes
      if (lim > 0 && $urandom_range(9) < 7) begin
        key = tbl_shadow[$urandom_range(lim - 1)];
      end else if ($urandom_range(19) == 0) begin
        key = '0;
      end
      pressed_keys.push_back(key);
      if (pressed_keys.size() > 12) void'(pressed_keys.pop_front());
      put_word(OP_PRESS, key, IDX_W'($urandom));
    end else if (roll < 55) begin
      if (pressed_keys.size() > 0 && $urandom_range(9) < 6) begin
        key = pressed_keys[$urandom_range(pressed_keys.size() - 1)];
      end
      put_word(OP_RELEASE, key, IDX_W'($urandom));
    end else if (roll < 60) begin
      put_word(OP_RELEASE_ALL, key, IDX_W'($urandom));
    end else if (roll < 82) begin
      put_word(OP_REPORT, key, IDX_W'($urandom));
    end else if (roll < 95) begin
      put_word(OP_LOAD, key, IDX_W'($urandom));
    end else begin
      put_word(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), key, IDX_W'($urandom));
    end
  endtask

  initial begin
    int                 seg;
    int                 n;
    logic [TSIZE_W-1:0] sizes [RAND_SEGMENTS];
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_PRESS;
    in_ch.key_value   = '0;
    in_ch.table_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.table_size = '0;
    out_ch.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_table_size(TSIZE_W'(0));
    put_word(OP_REPORT, 8'h00, 8'h00);
    put_word(OP_PRESS, 8'h00, 8'h00);
    put_word(OP_PRESS, 8'hFF, 8'hFF);
    put_word(OP_PRESS, 8'h01, 8'h00);
    put_word(OP_PRESS, 8'hFF, 8'h00);
    // duplicate entry at 2: lowest index wins
    put_word(OP_LOAD, 8'h01, 8'd0);
    put_word(OP_LOAD, 8'h41, 8'd1);
    put_word(OP_LOAD, 8'h01, 8'd2);
    put_word(OP_LOAD, 8'hFF, 8'd3);
    put_word(OP_LOAD, 8'h00, 8'd4);
    put_word(OP_LOAD, 8'h42, 8'd5);
    put_word(OP_LOAD, 8'hFF, 8'hFF);
    set_table_size(TSIZE_W'(6));
    put_word(OP_REPORT, 8'h00, 8'h00);
    // 55 and 10 are not in the table; 77 finds the slots full
    put_word(OP_PRESS, 8'h41, 8'h00);
    put_word(OP_PRESS, 8'h42, 8'h00);
    put_word(OP_PRESS, 8'h55, 8'h00);
    put_word(OP_PRESS, 8'h10, 8'h00);
    put_word(OP_PRESS, 8'h77, 8'h00);
    put_word(OP_REPORT, 8'h00, 8'h00);
    put_word(OP_RELEASE, 8'h01, 8'h00);
    put_word(OP_RELEASE, 8'h99, 8'h00);
    put_word(OP_RELEASE, 8'h00, 8'h00);
    put_word(OP_REPORT, 8'h00, 8'h00);
    put_word(OP_SPARE_LO, 8'hA5, 8'h5A);
    put_word(OP_SPARE_HI, 8'h5A, 8'hA5);
    put_word(OP_RELEASE_ALL, 8'h00, 8'h00);
    put_word(OP_REPORT, 8'h00, 8'h00);

    // whole table written before any larger size is used
    for (n = 6; n < TABLE_DEPTH; n++) put_word(OP_LOAD, KEY_W'($urandom), IDX_W'(n));

    sizes = '{TSIZE_W'(TABLE_DEPTH), TSIZE_W'($urandom_range(2, 255)), TSIZE_W'(1),
              TSIZE_W'(0), '1, TSIZE_W'($urandom)};
    for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
      set_table_size(sizes[seg]);
      case (seg % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 46;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 46;
        end
        default: begin
          src_idle_pct  = 12;
          snk_stall_pct = 12;
        end
      endcase
      for (n = 0; n < SEGMENT_WORDS; n++) random_word();
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("summary: %0d words sent, %0d results checked, %0d of them reports",
             words_sent, results, reports);
    $display("summary: table sizes 0, 1, 6, 256, 511 and random; four handshake mixes");
    if (errors == 0 && pending == 0) begin
      $display("hid_key_set_report_builder_top_tb: done, clean");
    end else begin
      $display("hid_key_set_report_builder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/hkrb_pkg.sv
hw/rtl/hkrb_if.sv
hw/rtl/hkrb_ram.sv
hw/rtl/hkrb_keyfind.sv
hw/rtl/hid_key_set_report_builder_top.sv
hw/rtl/hkrb_checker.sv
tb/sv/hkrb_report_checker.sv
tb/sv/hid_key_set_report_builder_top_tb.sv
